// File: design/twh_pkg.sv
// Shared types and codes for the topmost window hit-test block.
`default_nettype none

package twh_pkg;

    // request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CLICK = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS = 2'd1;

    // reset value of both grid size registers, truncated to the coordinate width
    localparam int GRID_RESET = 16383;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } twh_state_t;

    // control from the sequencer to the window table
    typedef struct packed {
        logic load_we;
        logic scan_start;
        logic raise_we;
    } tbl_ctrl_t;

    // status from the window table back to the sequencer
    typedef struct packed {
        logic scan_busy;
        logic found;
    } tbl_stat_t;

endpackage

`default_nettype wire

// File: design/twh_table.sv
// Window table: bounds and stamp memories, scan engine and best-window tracker.
`default_nettype none

module twh_table #(
    parameter int MAX_WINDOWS = 1024,
    parameter int COORD_BITS  = 14,
    parameter int STAMP_BITS  = 32,
    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
    localparam int CW = $clog2(MAX_WINDOWS + 1)
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire twh_pkg::tbl_ctrl_t        ctrl,
    output twh_pkg::tbl_stat_t             stat,
    input  wire [AW-1:0]                   load_addr,
    input  wire [COORD_BITS-1:0]           load_row_low,
    input  wire [COORD_BITS-1:0]           load_row_high,
    input  wire [COORD_BITS-1:0]           load_col_low,
    input  wire [COORD_BITS-1:0]           load_col_high,
    input  wire [STAMP_BITS-1:0]           load_stamp,
    input  wire [CW-1:0]                   scan_count,
    input  wire [COORD_BITS-1:0]           pt_row,
    input  wire [COORD_BITS-1:0]           pt_col,
    input  wire [STAMP_BITS-1:0]           raise_stamp,
    output logic [AW-1:0]                  best_idx
);

    localparam int BW = 4 * COORD_BITS;

    logic [BW-1:0]         bounds_mem [MAX_WINDOWS];
    logic [STAMP_BITS-1:0] stamp_mem  [MAX_WINDOWS];

    logic [BW-1:0]         bounds_rd;
    logic [STAMP_BITS-1:0] stamp_rd;

    logic                  busy_reg, busy_next;
    logic                  pend_reg, pend_next;
    logic [CW-1:0]         issue_reg, issue_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [STAMP_BITS-1:0] best_stamp_reg, best_stamp_next;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  stamp_we;
    logic [AW-1:0]         stamp_addr;
    logic [STAMP_BITS-1:0] stamp_wdata;

    logic [COORD_BITS-1:0] e_row_low, e_row_high, e_col_low, e_col_high;
    logic                  contains;
    logic                  better;

    assign rd_en   = busy_reg && (issue_reg < scan_count);
    assign rd_addr = issue_reg[AW-1:0];

    // stamp memory is written by a load or by the raise, never both at once
    assign stamp_we    = ctrl.load_we || ctrl.raise_we;
    assign stamp_addr  = ctrl.raise_we ? best_idx_reg : load_addr;
    assign stamp_wdata = ctrl.raise_we ? raise_stamp : load_stamp;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_we)
        begin
            bounds_mem[load_addr] <= {load_row_low, load_row_high, load_col_low, load_col_high};
        end
        if (rd_en)
        begin
            bounds_rd <= bounds_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_addr] <= stamp_wdata;
        end
        if (rd_en)
        begin
            stamp_rd <= stamp_mem[rd_addr];
        end
    end

    assign {e_row_low, e_row_high, e_col_low, e_col_high} = bounds_rd;

    assign contains = (pt_row >= e_row_low) && (pt_row <= e_row_high) &&
                      (pt_col >= e_col_low) && (pt_col <= e_col_high);
    // equal stamps: the later entry wins
    assign better   = !found_reg || (stamp_rd >= best_stamp_reg);

    always_comb
    begin
        busy_next       = busy_reg;
        pend_next       = pend_reg;
        issue_next      = issue_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;

        if (ctrl.scan_start)
        begin
            busy_next  = 1'b1;
            pend_next  = 1'b0;
            issue_next = '0;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (pend_reg && contains && better)
            begin
                found_next      = 1'b1;
                best_idx_next   = pend_idx_reg;
                best_stamp_next = stamp_rd;
            end
            if (rd_en)
            begin
                issue_next    = issue_reg + CW'(1);
                pend_next     = 1'b1;
                pend_idx_next = rd_addr;
            end
            else
            begin
                pend_next = 1'b0;
                if (!pend_reg)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign stat.scan_busy = busy_reg;
    assign stat.found     = found_reg;
    assign best_idx       = best_idx_reg;

endmodule

`default_nettype wire

// File: design/topmost_window_hit_and_raise.sv
// Topmost window hit test with raise: sequencer, counters, config and output register.
//
// Input channel (in_valid/in_ready): one word is a load (req_type 0) that
// stores the next window with inclusive row/column bounds, or a click
// (req_type 1) that asks which window lies on top at point_row/point_col.
// Output channel (out_valid/out_ready): one word per click, hit_window is the
// topmost containing window number plus one (0 for none or off grid), and
// stamp_overflow is set once the stacking counter has saturated.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 grid_rows,
// index 1 grid_cols; write only while the block is idle.
// A load leaves the block idle, so the next word can be taken in the next cycle.
// A click scans the window memory one entry per cycle, a rate set by the
// single read port of the table memories, and holds off the input until it
// finishes; an off-grid click, or one with no window loaded, skips the scan.
// The hit window is raised by rewriting its stamp as the click finishes.
// The output register holds a finished word while the receiver stalls; loads
// keep being taken, a further click is taken but waits until that word has left.
// Reset clears the window count, the stacking counter and the saturation flag,
// and returns the grid size to its full extent; the memories need no clearing.
`default_nettype none

module topmost_window_hit_and_raise #(
    parameter int MAX_WINDOWS = 1024,
    parameter int COORD_BITS  = 14,
    parameter int STAMP_BITS  = 32,
    localparam int HW = $clog2(MAX_WINDOWS + 1)
) (
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [twh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire [COORD_BITS-1:0]               cfg_data,

    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                req_type,
    input  wire [COORD_BITS-1:0]               row_low,
    input  wire [COORD_BITS-1:0]               row_high,
    input  wire [COORD_BITS-1:0]               col_low,
    input  wire [COORD_BITS-1:0]               col_high,
    input  wire [COORD_BITS-1:0]               point_row,
    input  wire [COORD_BITS-1:0]               point_col,

    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [HW-1:0]                      hit_window,
    output logic                               stamp_overflow
);

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CW = $clog2(MAX_WINDOWS + 1);

    twh_pkg::twh_state_t   state_reg, state_next;
    logic [COORD_BITS-1:0] grid_rows_reg, grid_cols_reg;
    logic [CW-1:0]         loaded_reg, loaded_next;
    logic [STAMP_BITS-1:0] counter_reg, counter_next;
    logic                  sat_reg, sat_next;

    logic [COORD_BITS-1:0] pt_row_reg, pt_col_reg;
    logic [STAMP_BITS-1:0] click_stamp_reg;
    logic                  click_ovf_reg;
    logic                  scanned_reg, scanned_next;

    logic                  out_valid_reg, out_valid_next;
    logic [HW-1:0]         hit_reg, hit_next;
    logic                  ovf_reg, ovf_next;

    logic                  accept;
    logic                  is_click;
    logic                  on_grid;
    logic                  table_full;
    logic                  out_free;
    logic                  click_hit;

    twh_pkg::tbl_ctrl_t    ctrl;
    twh_pkg::tbl_stat_t    stat;
    logic [AW-1:0]         best_idx;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == twh_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign is_click   = (req_type == twh_pkg::REQ_CLICK);
    assign table_full = (loaded_reg == CW'(MAX_WINDOWS));
    assign on_grid    = (point_row != '0) && (point_row <= grid_rows_reg) &&
                        (point_col != '0) && (point_col <= grid_cols_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign click_hit  = scanned_reg && stat.found;

    assign ctrl.load_we    = accept && !is_click && !table_full;
    assign ctrl.scan_start = accept && is_click && on_grid && (loaded_reg != '0);
    // rewriting the same stamp while the output stalls is harmless
    assign ctrl.raise_we   = (state_reg == twh_pkg::ST_DONE) && click_hit;

    twh_table #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .load_addr     (loaded_reg[AW-1:0]),
        .load_row_low  (row_low),
        .load_row_high (row_high),
        .load_col_low  (col_low),
        .load_col_high (col_high),
        .load_stamp    (counter_reg),
        .scan_count    (loaded_reg),
        .pt_row        (pt_row_reg),
        .pt_col        (pt_col_reg),
        .raise_stamp   (click_stamp_reg),
        .best_idx      (best_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        counter_next   = counter_reg;
        sat_next       = sat_reg;
        scanned_next   = scanned_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // every word advances the stacking counter, saturating at all ones
        if (accept)
        begin
            if (counter_reg == '1)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                counter_next = counter_reg + STAMP_BITS'(1);
            end
        end

        unique case (state_reg)
            twh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_click)
                    begin
                        scanned_next = ctrl.scan_start;
                        state_next   = ctrl.scan_start ? twh_pkg::ST_SCAN : twh_pkg::ST_DONE;
                    end
                    else if (!table_full)
                    begin
                        loaded_next = loaded_reg + CW'(1);
                    end
                end
            end
            twh_pkg::ST_SCAN:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = twh_pkg::ST_DONE;
                end
            end
            twh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = click_hit ? (HW'(best_idx) + HW'(1)) : '0;
                    ovf_next       = click_ovf_reg;
                    state_next     = twh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twh_pkg::ST_IDLE;
            grid_rows_reg <= COORD_BITS'(twh_pkg::GRID_RESET);
            grid_cols_reg <= COORD_BITS'(twh_pkg::GRID_RESET);
            loaded_reg    <= '0;
            counter_reg   <= '0;
            sat_reg       <= 1'b0;
            scanned_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            counter_reg   <= counter_next;
            sat_reg       <= sat_next;
            scanned_reg   <= scanned_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == twh_pkg::REG_GRID_ROWS)
                begin
                    grid_rows_reg <= cfg_data;
                end
                else if (cfg_index == twh_pkg::REG_GRID_COLS)
                begin
                    grid_cols_reg <= cfg_data;
                end
            end
        end
    end

    // hold the click operands for the scan and the result word
    always_ff @(posedge clk)
    begin
        if (accept && is_click)
        begin
            pt_row_reg      <= point_row;
            pt_col_reg      <= point_col;
            click_stamp_reg <= counter_reg;
            click_ovf_reg   <= sat_reg || (counter_reg == '1);
        end
        hit_reg <= hit_next;
        ovf_reg <= ovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign hit_window     = hit_reg;
    assign stamp_overflow = ovf_reg;

endmodule

`default_nettype wire

// File: design/twh_checker.sv
// Port-level checker for the topmost window hit-test block, with its bind.
`default_nettype none

module twh_checker #(
    parameter int MAX_WINDOWS = 1024,
    localparam int HW = $clog2(MAX_WINDOWS + 1)
) (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_valid,
    input wire                                in_ready,
    input wire                                req_type,
    input wire                                out_valid,
    input wire                                out_ready,
    input wire [HW-1:0]                       hit_window,
    input wire                                stamp_overflow
);

    logic ovf_seen_reg;
    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // remember that a delivered word already reported saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_seen_reg <= 1'b0;
        end
        else if (out_acc && stamp_overflow)
        begin
            ovf_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_window) && $stable(stamp_overflow))
        else $error("result word changed while stalled");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && ovf_seen_reg |-> stamp_overflow)
        else $error("saturation flag dropped");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit_window <= HW'(MAX_WINDOWS))
        else $error("hit number out of range");

    a_click_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (req_type == twh_pkg::REQ_CLICK) |=> !in_ready)
        else $error("click did not hold off the input");

    a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (req_type == twh_pkg::REQ_LOAD) |=> !$rose(out_valid))
        else $error("load produced a result word");

endmodule

bind topmost_window_hit_and_raise twh_checker #(
    .MAX_WINDOWS (MAX_WINDOWS)
) u_twh_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit_window     (hit_window),
    .stamp_overflow (stamp_overflow)
);

`default_nettype wire
